/* src/prl_pkg.sv */
// Package: constants and types shared by the request limiter modules.
`default_nettype none
package prl_pkg;

    localparam int TABLE_ENTRIES = 16;
    localparam int IDX_W         = $clog2(TABLE_ENTRIES);
    localparam int FILL_W        = $clog2(TABLE_ENTRIES + 1);
    localparam int ADDR_W        = 32;
    localparam int CNT_W         = 16;
    localparam logic [CNT_W-1:0] MAX_REQ_RESET = 16'd3;

    typedef struct packed {
        logic [ADDR_W-1:0] src;
        logic [CNT_W-1:0]  count;
    } entry_t;

    typedef enum logic {
        ST_IDLE,
        ST_SCAN
    } scan_state_t;

    typedef struct packed {
        logic valid;
        logic allowed;
        logic was_known;
    } result_t;

endpackage
`default_nettype wire

/* src/prl_ram.sv */
// Generic simple dual-port RAM with one write port and a registered read port.
`default_nettype none
module prl_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output      logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule
`default_nettype wire

/* src/prl_scan.sv */
// Table search sequencer: pipelined scan of the source table and read-modify-write update.
`default_nettype none
module prl_scan (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         start,
    input  wire logic [prl_pkg::ADDR_W-1:0]   source_address,
    input  wire logic [prl_pkg::CNT_W-1:0]    max_requests,
    output      logic                         busy,
    output      prl_pkg::result_t             result
);
    import prl_pkg::*;

    scan_state_t       state_reg, state_next;
    logic [ADDR_W-1:0] src_reg, src_next;
    logic [FILL_W-1:0] rd_idx_reg, rd_idx_next;
    logic [IDX_W-1:0]  cmp_idx_reg, cmp_idx_next;
    logic              cmp_vld_reg, cmp_vld_next;
    logic [FILL_W-1:0] fill_reg, fill_next;
    logic [IDX_W-1:0]  ptr_reg, ptr_next;

    logic              rd_en;
    logic              hit;
    logic              miss_done;
    logic              table_full;
    logic [IDX_W-1:0]  miss_slot;
    logic              ram_we;
    logic [IDX_W-1:0]  ram_waddr;
    entry_t            ram_wdata;
    entry_t            ram_rdata;

    prl_ram #(
        .WIDTH ($bits(entry_t)),
        .DEPTH (TABLE_ENTRIES)
    ) u_table (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (rd_en),
        .raddr (rd_idx_reg[IDX_W-1:0]),
        .rdata (ram_rdata)
    );

    assign table_full = (fill_reg == FILL_W'(TABLE_ENTRIES));
    assign miss_slot  = table_full ? ptr_reg : fill_reg[IDX_W-1:0];
    assign rd_en      = (state_reg == ST_SCAN) && (rd_idx_reg < fill_reg);
    assign hit        = (state_reg == ST_SCAN) && cmp_vld_reg && (ram_rdata.src == src_reg);
    // Miss once the last valid entry has been compared and nothing is still in flight
    assign miss_done  = (state_reg == ST_SCAN) && !hit && !rd_en;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                if (hit || miss_done)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        busy         = (state_reg != ST_IDLE);
        src_next     = src_reg;
        rd_idx_next  = rd_idx_reg;
        cmp_idx_next = rd_idx_reg[IDX_W-1:0];
        cmp_vld_next = rd_en;
        fill_next    = fill_reg;
        ptr_next     = ptr_reg;
        ram_we       = 1'b0;
        ram_waddr    = miss_slot;
        ram_wdata    = '{src: src_reg, count: CNT_W'(1)};
        result       = '{valid: 1'b0, allowed: 1'b0, was_known: 1'b0};
        case (state_reg)
            ST_IDLE:
            begin
                cmp_vld_next = 1'b0;
                if (start)
                begin
                    src_next    = source_address;
                    rd_idx_next = '0;
                end
            end
            ST_SCAN:
            begin
                if (rd_en)
                begin
                    rd_idx_next = rd_idx_reg + FILL_W'(1);
                end
                if (hit)
                begin
                    result.valid     = 1'b1;
                    result.was_known = 1'b1;
                    ram_waddr        = cmp_idx_reg;
                    ram_wdata        = '{src: src_reg, count: ram_rdata.count + CNT_W'(1)};
                    // Refuse at or above the limit, otherwise count this transfer
                    if (ram_rdata.count >= max_requests)
                    begin
                        result.allowed = 1'b0;
                    end
                    else
                    begin
                        result.allowed = 1'b1;
                        ram_we         = 1'b1;
                    end
                end
                else if (miss_done)
                begin
                    result.valid     = 1'b1;
                    result.allowed   = 1'b1;
                    result.was_known = 1'b0;
                    ram_we           = 1'b1;
                    if (table_full)
                    begin
                        ptr_next = (ptr_reg == IDX_W'(TABLE_ENTRIES - 1)) ?
                                   '0 : ptr_reg + IDX_W'(1);
                    end
                    else
                    begin
                        fill_next = fill_reg + FILL_W'(1);
                    end
                end
            end
            default:
            begin
                cmp_vld_next = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            cmp_vld_reg <= 1'b0;
            fill_reg    <= '0;
            ptr_reg     <= '0;
        end
        else
        begin
            state_reg   <= state_next;
            cmp_vld_reg <= cmp_vld_next;
            fill_reg    <= fill_next;
            ptr_reg     <= ptr_next;
        end
    end

    always_ff @(posedge clk)
    begin
        src_reg     <= src_next;
        rd_idx_reg  <= rd_idx_next;
        cmp_idx_reg <= cmp_idx_next;
    end

    a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
        fill_reg <= FILL_W'(TABLE_ENTRIES))
        else $error("fill level beyond table size");

    a_write_in_scan: assert property (@(posedge clk) disable iff (!rst_n)
        ram_we |-> (state_reg == ST_SCAN) && result.valid)
        else $error("table written outside a result cycle");

    a_result_ends_item: assert property (@(posedge clk) disable iff (!rst_n)
        result.valid |=> (state_reg == ST_IDLE))
        else $error("scan continued after result");

    a_ptr_only_full: assert property (@(posedge clk) disable iff (!rst_n)
        (ptr_reg != ptr_next) |-> table_full)
        else $error("replace pointer moved while table not full");

    a_read_below_fill: assert property (@(posedge clk) disable iff (!rst_n)
        cmp_vld_reg |-> ({1'b0, cmp_idx_reg} < fill_reg))
        else $error("compare of an unwritten entry");

endmodule
`default_nettype wire

/* src/per_source_request_limiter.sv */
// Top level of the per-source request limiter: limit register, scan sequencer, result register.
// On a miss every valid entry is read and compared; on a hit the scan stops at the matching entry;
// one table entry is read per cycle from a single RAM read port.
// Requests are not overlapped: start is ignored while busy; busy falls as the result is strobed.
// Results are strobed for one cycle and cannot be stalled.
// Reset: table empty, replace pointer zero, max_requests back to 3; table RAM is not cleared.
`default_nettype none
module per_source_request_limiter (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         start,
    output      logic                         busy,
    input  wire logic [prl_pkg::ADDR_W-1:0]   source_address,
    input  wire logic                         max_requests_we,
    input  wire logic [prl_pkg::CNT_W-1:0]    max_requests,
    output      logic                         result_valid,
    output      logic                         allowed,
    output      logic                         was_known
);
    import prl_pkg::*;

    logic [CNT_W-1:0] max_req_reg, max_req_next;
    result_t          res_reg;
    result_t          scan_res;

    prl_scan u_scan (
        .clk            (clk),
        .rst_n          (rst_n),
        .start          (start),
        .source_address (source_address),
        .max_requests   (max_req_reg),
        .busy           (busy),
        .result         (scan_res)
    );

    assign max_req_next = max_requests_we ? max_requests : max_req_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_req_reg <= MAX_REQ_RESET;
            res_reg     <= '0;
        end
        else
        begin
            max_req_reg <= max_req_next;
            res_reg     <= scan_res;
        end
    end

    assign result_valid = res_reg.valid;
    assign allowed      = res_reg.allowed;
    assign was_known    = res_reg.was_known;

endmodule
`default_nettype wire
